>>> sv/lru_pkg.sv
// Package for the LRU page replacement block: defaults, state codes and chain types.
`timescale 1ns / 1ps
`default_nettype none

package lru_pkg;

  localparam int DEF_FRAMES    = 16;
  localparam int DEF_PAGE_BITS = 16;

  // Fixed widths of the external fields.
  localparam int PAGE_PORT_W  = 16;
  localparam int INDEX_PORT_W = 4;
  localparam int COUNT_PORT_W = 5;
  localparam int FAULT_W      = 32;

  localparam logic [COUNT_PORT_W-1:0] FRAME_COUNT_RST = COUNT_PORT_W'(16);
  localparam logic [FAULT_W-1:0]      FAULT_MAX       = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } lru_state_e;

  // Search token at the default build size; the top level hands down its own.
  typedef struct packed {
    logic        vld;
    logic [15:0] page;
    logic        found;
    logic [3:0]  fidx;
    logic [3:0]  frank;
    logic        bvld;
    logic [3:0]  bidx;
    logic [3:0]  brank;
    logic [15:0] bpage;
  } lru_tok_t;

  // Update broadcast at the default build size.
  typedef struct packed {
    logic        en;
    logic        clr;
    logic [3:0]  idx;
    logic [4:0]  old;
    logic [15:0] page;
  } lru_upd_t;

endpackage

`default_nettype wire

>>> sv/lru_cell.sv
// One page frame: holds page, valid and recency rank, and forwards the search token.
`timescale 1ns / 1ps
`default_nettype none

module lru_cell import lru_pkg::*; #(
  parameter int  INDEX     = 0,
  parameter int  FRAMES    = DEF_FRAMES,
  parameter int  PAGE_BITS = DEF_PAGE_BITS,
  parameter type tok_t     = lru_tok_t,
  parameter type upd_t     = lru_upd_t
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [$clog2(FRAMES+1)-1:0] eff_i,
  input  tok_t tok_i,
  output tok_t tok_o,
  input  upd_t upd_i
);

  localparam int PW     = (PAGE_BITS < PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;
  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES+1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

  logic             valid_q;
  logic [PW-1:0]    page_q;
  logic [IDX_W-1:0] rank_q;
  tok_t             tok_d, tok_q;
  logic             in_use;

  assign in_use = valid_q && (MY_POS < eff_i);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld) begin
      // The lowest matching frame wins because the token keeps the first hit.
      if (in_use && !tok_i.found && (page_q == tok_i.page)) begin
        tok_d.found = 1'b1;
        tok_d.fidx  = MY_IDX;
        tok_d.frank = rank_q;
      end
      if (in_use && (!tok_i.bvld || (rank_q > tok_i.brank))) begin
        tok_d.bvld  = 1'b1;
        tok_d.bidx  = MY_IDX;
        tok_d.brank = rank_q;
        tok_d.bpage = page_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (upd_i.clr) begin
      valid_q <= 1'b0;
    end else if (upd_i.en && (upd_i.idx == MY_IDX)) begin
      valid_q <= 1'b1;
    end
  end

  // Frames newer than the touched one age by one step.
  always_ff @(posedge clk_i) begin
    if (upd_i.en && !upd_i.clr) begin
      if (upd_i.idx == MY_IDX) begin
        page_q <= upd_i.page;
        rank_q <= '0;
      end else if (valid_q && (CNT_W'(rank_q) < upd_i.old)) begin
        rank_q <= rank_q + IDX_W'(1);
      end
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

>>> sv/lru_page_replacement.sv
// Top level of the LRU page replacement block: control, counters and the frame chain.
//
//   Channel  | Signals                                    | Transfer when
//   ---------+--------------------------------------------+---------------------------
//   input    | page_number_i, end_of_string_i             | in_valid_i && !in_stall_o
//   output   | hit_o, frame_index_o, evicted_valid_o,     | out_valid_o && !out_stall_i
//            | evicted_page_o, fault_count_o              |
//   config   | cfg_wdata_i (frame_count)                  | cfg_we_i
//
// A new input transfer is taken only after the previous reference has committed: the search
// token walks the chain one frame per cycle, then it is captured in fin_q and committed.
// The commit waits while the previous result is still held in the output register.
// Reset empties all frames and clears the fill and fault counters; frame_count returns to 16.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement import lru_pkg::*; #(
  parameter int FRAMES    = DEF_FRAMES,
  parameter int PAGE_BITS = DEF_PAGE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [PAGE_PORT_W-1:0]  page_number_i,
  input  logic                    end_of_string_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o,
  output logic [INDEX_PORT_W-1:0] frame_index_o,
  output logic                    evicted_valid_o,
  output logic [PAGE_PORT_W-1:0]  evicted_page_o,
  output logic [FAULT_W-1:0]      fault_count_o,
  input  logic                    cfg_we_i,
  input  logic [COUNT_PORT_W-1:0] cfg_wdata_i
);

  localparam int PW    = (PAGE_BITS < PAGE_PORT_W) ? PAGE_BITS : PAGE_PORT_W;
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES+1);

  typedef struct packed {
    logic             vld;
    logic [PW-1:0]    page;
    logic             found;
    logic [IDX_W-1:0] fidx;
    logic [IDX_W-1:0] frank;
    logic             bvld;
    logic [IDX_W-1:0] bidx;
    logic [IDX_W-1:0] brank;
    logic [PW-1:0]    bpage;
  } cell_tok_t;

  typedef struct packed {
    logic             en;
    logic             clr;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] old;
    logic [PW-1:0]    page;
  } cell_upd_t;

  lru_state_e              state_q, state_d;
  logic [COUNT_PORT_W-1:0] fc_q;
  logic [CNT_W-1:0]        fill_q;
  logic [FAULT_W-1:0]      faults_q;
  logic                    last_q;
  cell_tok_t               fin_q;

  logic                    out_valid_q;
  logic                    hit_q;
  logic [INDEX_PORT_W-1:0] index_q;
  logic                    ev_valid_q;
  logic [PAGE_PORT_W-1:0]  ev_page_q;
  logic [FAULT_W-1:0]      fault_out_q;

  cell_tok_t               head;
  cell_tok_t               chain [FRAMES];
  cell_upd_t               upd;
  logic [CNT_W-1:0]        eff;
  logic [31:0]             fc_wide;

  logic                    accept, commit, fill_free;
  logic [IDX_W-1:0]        sel_idx;
  logic [CNT_W-1:0]        sel_old;
  logic                    sel_ev;
  logic [FAULT_W-1:0]      faults_new;

  // Out-of-range counts are clamped into 1..FRAMES.
  assign fc_wide = 32'(fc_q);
  always_comb begin
    if (fc_wide == 32'd0) begin
      eff = CNT_W'(1);
    end else if (fc_wide > 32'(FRAMES)) begin
      eff = CNT_W'(FRAMES);
    end else begin
      eff = CNT_W'(fc_wide);
    end
  end

  assign accept = (state_q == ST_IDLE) && in_valid_i;
  assign commit = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    head      = '0;
    head.vld  = accept;
    head.page = page_number_i[PW-1:0];
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lru_cell #(
      .INDEX    (g),
      .FRAMES   (FRAMES),
      .PAGE_BITS(PAGE_BITS),
      .tok_t    (cell_tok_t),
      .upd_t    (cell_upd_t)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .eff_i (eff),
      .tok_i ((g == 0) ? head : chain[(g == 0) ? 0 : g-1]),
      .tok_o (chain[g]),
      .upd_i (upd)
    );
  end

  // Replacement decision from the finished token.
  assign fill_free = fill_q < eff;
  always_comb begin
    sel_ev = 1'b0;
    if (fin_q.found) begin
      sel_idx = fin_q.fidx;
      sel_old = CNT_W'(fin_q.frank);
    end else if (fill_free) begin
      sel_idx = IDX_W'(fill_q);
      sel_old = CNT_W'(FRAMES);
    end else begin
      sel_idx = fin_q.bidx;
      sel_old = CNT_W'(fin_q.brank);
      sel_ev  = fin_q.bvld;
    end
  end

  assign faults_new = (fin_q.found || (faults_q == FAULT_MAX)) ? faults_q
                                                               : faults_q + FAULT_W'(1);

  always_comb begin
    upd      = '0;
    upd.en   = commit;
    upd.clr  = commit && last_q;
    upd.idx  = sel_idx;
    upd.old  = sel_old;
    upd.page = fin_q.page;
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (chain[FRAMES-1].vld) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= FRAME_COUNT_RST;
    end else if (cfg_we_i) begin
      fc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      faults_q <= '0;
    end else if (commit) begin
      if (last_q) begin
        fill_q   <= '0;
        faults_q <= '0;
      end else begin
        faults_q <= faults_new;
        if (!fin_q.found && fill_free) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= end_of_string_i;
    end
    if ((state_q == ST_SEARCH) && chain[FRAMES-1].vld) begin
      fin_q <= chain[FRAMES-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q       <= fin_q.found;
      index_q     <= INDEX_PORT_W'(sel_idx);
      ev_valid_q  <= sel_ev;
      ev_page_q   <= sel_ev ? PAGE_PORT_W'(fin_q.bpage) : '0;
      fault_out_q <= faults_new;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = index_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_out_q;

endmodule

`default_nettype wire
